[design/oal_pkg.sv]
// Shared types and constants for the ordered array list engine.
package oal_pkg;

  // Storage geometry
  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int CAP_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 9;
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // First-match tree: cells grouped in fixed-size groups
  localparam int GRP    = 16;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGROUP = (CAPACITY + GRP - 1) / GRP;

  // Stream word widths
  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

  // Request kinds
  typedef enum logic [2:0] {
    K_READ   = 3'd0,
    K_WRITE  = 3'd1,
    K_INSERT = 3'd2,
    K_REMOVE = 3'd3,
    K_FIND   = 3'd4,
    K_REMVAL = 3'd5,
    K_APPEND = 3'd6
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    C_HOLD,
    C_COMPARE,
    C_WRITE,
    C_INSERT,
    C_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [CAP_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
    logic [CNT_W-1:0]   count;
  } cell_cmd_t;

  // Controller state
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

[design/oal_cell.sv]
// One storage cell of the list: holds an entry, shifts with its neighbors, compares.
module oal_cell import oal_pkg::*; (
  input  logic              clk,
  input  logic [CAP_W-1:0]  cell_idx,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] entry,
  output logic              match
);

  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic              match_r, match_nxt;
  logic              at_pos, above_pos;

  assign at_pos    = (cell_idx == cmd.pos);
  assign above_pos = (cell_idx > cmd.pos);

  // Next entry and match flag
  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    case (cmd.op)
      C_COMPARE: match_nxt = (entry_r == cmd.value) && (CNT_W'(cell_idx) < cmd.count);
      C_WRITE:   if (at_pos) entry_nxt = cmd.value;
      C_INSERT: begin
        if (at_pos) entry_nxt = cmd.value;
        else if (above_pos) entry_nxt = left_val;
      end
      C_REMOVE:  if (at_pos || above_pos) entry_nxt = right_val;
      default: ;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

[design/oal_pick.sv]
// Two-level registered first-match encoder and read-word selector over all cells.
module oal_pick import oal_pkg::*; (
  input  logic                             clk,
  input  logic                             look_en,
  input  logic                             scan_en,
  input  logic [IDX_W-1:0]                 idx,
  input  logic [CAPACITY-1:0][DATA_W-1:0]  entries,
  input  logic [CAPACITY-1:0]              hits,
  output logic [DATA_W-1:0]                rd_word,
  output logic                             found,
  output logic [CAP_W-1:0]                 found_pos
);

  logic [NGROUP-1:0][DATA_W-1:0] grp_word_r, grp_word_nxt;
  logic [DATA_W-1:0]             word_r, word_nxt;
  logic [NGROUP-1:0]             grp_any_r, grp_any_nxt;
  logic [NGROUP-1:0][GRP_W-1:0]  grp_first_r, grp_first_nxt;

  // Level one of the read path: pick the word inside each group
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_word_nxt[g] = grp_word_r[g];
      if (look_en) begin
        grp_word_nxt[g] = '0;
        for (int l = 0; l < GRP; l++) begin
          if ((g * GRP + l < CAPACITY) && (GRP_W'(l) == idx[GRP_W-1:0]))
            grp_word_nxt[g] = entries[g * GRP + l];
        end
      end
    end
  end

  // Level two of the read path and level one of the match encoder
  always_comb begin
    word_nxt      = word_r;
    grp_any_nxt   = grp_any_r;
    grp_first_nxt = grp_first_r;
    if (scan_en) begin
      word_nxt = '0;
      for (int g = 0; g < NGROUP; g++) begin
        if (IDX_W'(g) == (idx >> GRP_W)) word_nxt = grp_word_r[g];
      end
      for (int g = 0; g < NGROUP; g++) begin
        grp_any_nxt[g]   = 1'b0;
        grp_first_nxt[g] = '0;
        for (int l = GRP - 1; l >= 0; l--) begin
          if ((g * GRP + l < CAPACITY) && hits[g * GRP + l]) begin
            grp_any_nxt[g]   = 1'b1;
            grp_first_nxt[g] = GRP_W'(l);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_word_r  <= grp_word_nxt;
    word_r      <= word_nxt;
    grp_any_r   <= grp_any_nxt;
    grp_first_r <= grp_first_nxt;
  end

  // Final level: lowest group with a hit
  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int g = NGROUP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found     = 1'b1;
        found_pos = CAP_W'(g * GRP) + CAP_W'(grp_first_r[g]);
      end
    end
  end

  assign rd_word = word_r;

endmodule

[design/ordered_array_list_engine.sv]
// Ordered array list engine: a row of entry cells behind a small request controller.
//
// Usage: each input word carries a request (kind, index, value); each request
// returns exactly one output word (status, read_value, position, count), in
// order. Kinds are read, write, insert, remove at position, find, remove first
// match and append. Capacity is fixed at CAPACITY entries; inserting at a valid
// position of a full list returns status "list full" and leaves the list unchanged.
// Flow: a request is taken in the idle state, then the cells compare in parallel,
// a two-level registered encoder finds the first match (and selects the read
// word), and in the commit state all cells shift or write at once while the
// result is registered. The controller steps through four states, capture,
// compare, encode, commit, and takes no new request until the previous one commits.
// A finished result sits in an output register; the next request is accepted
// while it waits. If the receiver stalls, the following request finishes its
// search and then holds, without touching the list, until the output is free.
// Reset empties the list (count zero); entry contents need no clearing.
module ordered_array_list_engine import oal_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // kind[2:0], index[11:3], value[43:12]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status[1:0], read_value[33:2], position[41:34], count[50:42]
);

  state_t            state_r, state_nxt;
  kind_t             kind_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic              accept, slot_free, commit, look_en, scan_en;
  cell_cmd_t         cmd, commit_cmd;
  status_t           res_status;
  logic [DATA_W-1:0] res_read;
  logic [CAP_W-1:0]  res_pos;

  logic [CAPACITY-1:0][DATA_W-1:0] entries;
  logic [CAPACITY-1:0]             hits;
  logic [DATA_W-1:0]               rd_word;
  logic                            found;
  logic [CAP_W-1:0]                found_pos;

  logic [CMP_W-1:0] idx_ext, cnt_ext;
  logic             idx_in_list, idx_past_end, is_full;

  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_SCAN;
      S_SCAN:   state_nxt = S_COMMIT;
      S_COMMIT: if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_tready = 1'b0;
    look_en   = 1'b0;
    scan_en   = 1'b0;
    commit    = 1'b0;
    case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_LOOK:   look_en   = 1'b1;
      S_SCAN:   scan_en   = 1'b1;
      S_COMMIT: commit    = slot_free;
      default: ;
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_t'(in_tdata[2:0]);
      idx_r   <= in_tdata[11:3];
      value_r <= in_tdata[43:12];
    end
  end

  // Position checks
  assign idx_ext      = CMP_W'(idx_r);
  assign cnt_ext      = CMP_W'(count_r);
  assign idx_in_list  = idx_ext < cnt_ext;
  assign idx_past_end = idx_ext > cnt_ext;
  assign is_full      = cnt_ext >= CMP_W'(CAPACITY);

  // Decision for the request at commit
  always_comb begin
    res_status       = ST_OK;
    res_read         = '0;
    res_pos          = '0;
    count_nxt        = count_r;
    commit_cmd.op    = C_HOLD;
    commit_cmd.pos   = CAP_W'(idx_r);
    commit_cmd.value = value_r;
    commit_cmd.count = count_r;
    case (kind_r)
      K_READ: begin
        if (idx_in_list) res_read = rd_word;
        else res_status = ST_BADPOS;
      end
      K_WRITE: begin
        if (idx_in_list) commit_cmd.op = C_WRITE;
        else res_status = ST_BADPOS;
      end
      K_INSERT: begin
        if (idx_past_end) res_status = ST_BADPOS;
        else if (is_full) res_status = ST_FULL;
        else begin
          commit_cmd.op = C_INSERT;
          count_nxt     = count_r + 1'b1;
        end
      end
      K_REMOVE: begin
        if (idx_in_list) begin
          commit_cmd.op = C_REMOVE;
          count_nxt     = count_r - 1'b1;
        end else res_status = ST_BADPOS;
      end
      K_FIND: begin
        if (found) res_pos = found_pos;
        else res_status = ST_NOTFOUND;
      end
      K_REMVAL: begin
        if (found) begin
          res_pos        = found_pos;
          commit_cmd.op  = C_REMOVE;
          commit_cmd.pos = found_pos;
          count_nxt      = count_r - 1'b1;
        end else res_status = ST_NOTFOUND;
      end
      K_APPEND: begin
        if (is_full) res_status = ST_FULL;
        else begin
          commit_cmd.op  = C_INSERT;
          commit_cmd.pos = CAP_W'(count_r);
          count_nxt      = count_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Command to the cell row
  always_comb begin
    cmd       = commit_cmd;
    cmd.count = count_r;
    if (look_en) cmd.op = C_COMPARE;
    else if (!commit) cmd.op = C_HOLD;
  end

  // Count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {5'b0, IDX_W'(count_nxt), 8'(res_pos), res_read, res_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Row of cells; each shifts to or from its direct neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = cmd.value;
    end else begin : g_mid_l
      assign left_v = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = entries[i];
    end else begin : g_mid_r
      assign right_v = entries[i+1];
    end
    oal_cell u_cell (
      .clk       (clk),
      .cell_idx  (CAP_W'(i)),
      .cmd       (cmd),
      .left_val  (left_v),
      .right_val (right_v),
      .entry     (entries[i]),
      .match     (hits[i])
    );
  end

  oal_pick u_pick (
    .clk       (clk),
    .look_en   (look_en),
    .scan_en   (scan_en),
    .idx       (idx_r),
    .entries   (entries),
    .hits      (hits),
    .rd_word   (rd_word),
    .found     (found),
    .found_pos (found_pos)
  );

  // Count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Count moves only when a request commits
  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(count_r))
    else $error("count changed outside commit");

  // A commit always presents a result
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit without result");

  // A remove shortens the list by one
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && cmd.op == C_REMOVE) |=> (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("remove did not decrement count");

endmodule
